### rtl/priority_status_lamp_arbiter_unit_defines.svh
// Assertion macros shared by the status lamp arbiter modules.
`ifndef PRIORITY_STATUS_LAMP_ARBITER_UNIT_DEFINES_SVH
`define PRIORITY_STATUS_LAMP_ARBITER_UNIT_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define PSLA_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks a consequence in the same cycle as its antecedent.
`define PSLA_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define PSLA_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/psla_pkg.sv
// Package with types, codes and constants of the status lamp arbiter.
package psla_pkg;

   localparam int LAYER_LAMP_PRESENT_DEFAULT = 1;
   localparam int TIME_BITS_DEFAULT = 32;
   localparam int NUM_LAMPS = 3;
   localparam int CSR_INDEX_BITS = 4;

   localparam int LAMP_BATTERY = 0;
   localparam int LAMP_LINK = 1;
   localparam int LAMP_LAYER = 2;

   typedef enum logic [1:0] {OP_POLL, OP_BATTERY, OP_LINK, OP_LAYER} op_type;
   typedef enum logic [1:0] {OWN_NONE, OWN_BATTERY, OWN_LINK, OWN_LAYER} owner_type;
   typedef enum logic [1:0] {PRIO_LINK, PRIO_BATTERY, PRIO_LAYER, PRIO_IDLE} prio_type;
   typedef enum logic [1:0] {ST_ASSIGNED, ST_BUSY, ST_POLL} outcome_type;

   localparam logic [1:0] LINK_CONNECTED = 2'd0;
   localparam logic [1:0] LINK_ADVERTISING = 2'd1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BATTERY_BLINK = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINK_BLINK = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LAYER_BLINK = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHOW_TIMEOUT = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHARE_TIMEOUT = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CRITICAL_LEVEL = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_LEVEL = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_LEVEL = 4'd7;

   localparam logic [15:0] BATTERY_BLINK_RESET = 16'd1000;
   localparam logic [15:0] LINK_BLINK_RESET = 16'd500;
   localparam logic [15:0] LAYER_BLINK_RESET = 16'd250;
   localparam logic [31:0] SHOW_TIMEOUT_RESET = 32'd5000;
   localparam logic [31:0] SHARE_TIMEOUT_RESET = 32'd1000;
   localparam logic [6:0] CRITICAL_LEVEL_RESET = 7'd5;
   localparam logic [6:0] LOW_LEVEL_RESET = 7'd20;
   localparam logic [6:0] HIGH_LEVEL_RESET = 7'd80;

   localparam logic [15:0] UNKNOWN_LEVEL_PERIOD = 16'd200;
   localparam logic [15:0] CRITICAL_PERIOD = 16'd100;

   typedef struct packed {
      logic [15:0] battery_blink_ms;
      logic [15:0] link_blink_ms;
      logic [15:0] layer_blink_ms;
      logic [31:0] show_timeout_ms;
      logic [31:0] share_timeout_ms;
      logic [6:0]  critical_level;
      logic [6:0]  low_level;
      logic [6:0]  high_level;
   } cfg_type;

   typedef struct packed {
      logic [NUM_LAMPS-1:0] take;
      owner_type            owner;
      prio_type             prio;
      logic [15:0]          period;
      logic                 blinking;
      logic [31:0]          timeout;
      logic                 shared;
   } cmd_type;

   typedef struct packed {
      owner_type owner;
      prio_type  prio;
      logic      lit_next;
   } lamp_state_type;

endpackage

### rtl/psla_csr.sv
// Configuration registers of the status lamp arbiter.
module psla_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [psla_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]                         csr_data,
   output psla_pkg::cfg_type                   cfg
);

   psla_pkg::cfg_type cfg_ff;
   psla_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            psla_pkg::CSR_BATTERY_BLINK:  cfg_in.battery_blink_ms = csr_data[15:0];
            psla_pkg::CSR_LINK_BLINK:     cfg_in.link_blink_ms = csr_data[15:0];
            psla_pkg::CSR_LAYER_BLINK:    cfg_in.layer_blink_ms = csr_data[15:0];
            psla_pkg::CSR_SHOW_TIMEOUT:   cfg_in.show_timeout_ms = csr_data;
            psla_pkg::CSR_SHARE_TIMEOUT:  cfg_in.share_timeout_ms = csr_data;
            psla_pkg::CSR_CRITICAL_LEVEL: cfg_in.critical_level = csr_data[6:0];
            psla_pkg::CSR_LOW_LEVEL:      cfg_in.low_level = csr_data[6:0];
            psla_pkg::CSR_HIGH_LEVEL:     cfg_in.high_level = csr_data[6:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.battery_blink_ms <= psla_pkg::BATTERY_BLINK_RESET;
         cfg_ff.link_blink_ms <= psla_pkg::LINK_BLINK_RESET;
         cfg_ff.layer_blink_ms <= psla_pkg::LAYER_BLINK_RESET;
         cfg_ff.show_timeout_ms <= psla_pkg::SHOW_TIMEOUT_RESET;
         cfg_ff.share_timeout_ms <= psla_pkg::SHARE_TIMEOUT_RESET;
         cfg_ff.critical_level <= psla_pkg::CRITICAL_LEVEL_RESET;
         cfg_ff.low_level <= psla_pkg::LOW_LEVEL_RESET;
         cfg_ff.high_level <= psla_pkg::HIGH_LEVEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/psla_decode.sv
// Request decoder that maps a transaction to a lamp assignment command.
module psla_decode #(
   parameter int LAYER_LAMP_PRESENT = psla_pkg::LAYER_LAMP_PRESENT_DEFAULT
) (
   input  psla_pkg::op_type       op,
   input  logic [6:0]             charge_pct,
   input  logic [1:0]             link_state,
   input  psla_pkg::cfg_type      cfg,
   input  psla_pkg::lamp_state_type lamp_st [psla_pkg::NUM_LAMPS],
   output psla_pkg::cmd_type      cmd,
   output psla_pkg::outcome_type  status
);

   logic [15:0] battery_period;
   logic        battery_solid;
   logic [15:0] link_period;
   logic        link_solid;

   function automatic logic free_for(psla_pkg::lamp_state_type st, psla_pkg::prio_type prio);
      return (st.owner == psla_pkg::OWN_NONE) || (prio <= st.prio);
   endfunction

   always_comb begin
      battery_period = cfg.battery_blink_ms;
      battery_solid = 1'b0;
      priority if (charge_pct == 7'd0) begin
         battery_period = psla_pkg::UNKNOWN_LEVEL_PERIOD;
      end else if (charge_pct <= cfg.critical_level) begin
         battery_period = psla_pkg::CRITICAL_PERIOD;
      end else if (charge_pct <= cfg.low_level) begin
         battery_period = cfg.battery_blink_ms >> 1;
      end else if (charge_pct >= cfg.high_level) begin
         battery_solid = 1'b1;
      end else begin
         battery_period = cfg.battery_blink_ms;
      end
   end

   always_comb begin
      link_period = cfg.link_blink_ms;
      link_solid = 1'b0;
      priority if (link_state == psla_pkg::LINK_CONNECTED) begin
         link_solid = 1'b1;
      end else if (link_state != psla_pkg::LINK_ADVERTISING) begin
         link_period = cfg.link_blink_ms >> 1;
      end else begin
         link_period = cfg.link_blink_ms;
      end
   end

   always_comb begin
      cmd = '0;
      cmd.owner = psla_pkg::OWN_NONE;
      cmd.prio = psla_pkg::PRIO_IDLE;
      status = psla_pkg::ST_POLL;
      unique case (op)
         psla_pkg::OP_POLL: begin
            status = psla_pkg::ST_POLL;
         end
         psla_pkg::OP_BATTERY: begin
            cmd.owner = psla_pkg::OWN_BATTERY;
            cmd.prio = psla_pkg::PRIO_BATTERY;
            cmd.period = battery_period;
            cmd.blinking = !battery_solid;
            cmd.timeout = cfg.show_timeout_ms;
            if (free_for(lamp_st[psla_pkg::LAMP_BATTERY], psla_pkg::PRIO_BATTERY)) begin
               cmd.take[psla_pkg::LAMP_BATTERY] = 1'b1;
               status = psla_pkg::ST_ASSIGNED;
            end else begin
               status = psla_pkg::ST_BUSY;
            end
         end
         psla_pkg::OP_LINK: begin
            cmd.owner = psla_pkg::OWN_LINK;
            cmd.prio = psla_pkg::PRIO_LINK;
            cmd.period = link_period;
            cmd.blinking = !link_solid;
            cmd.timeout = cfg.show_timeout_ms;
            if (free_for(lamp_st[psla_pkg::LAMP_LINK], psla_pkg::PRIO_LINK)) begin
               cmd.take[psla_pkg::LAMP_LINK] = 1'b1;
               status = psla_pkg::ST_ASSIGNED;
            end else begin
               status = psla_pkg::ST_BUSY;
            end
         end
         psla_pkg::OP_LAYER: begin
            cmd.owner = psla_pkg::OWN_LAYER;
            cmd.prio = psla_pkg::PRIO_LAYER;
            cmd.period = cfg.layer_blink_ms;
            cmd.blinking = 1'b1;
            cmd.timeout = cfg.share_timeout_ms;
            status = psla_pkg::ST_ASSIGNED;
            priority if ((LAYER_LAMP_PRESENT != 0) &&
                          free_for(lamp_st[psla_pkg::LAMP_LAYER], psla_pkg::PRIO_LAYER)) begin
               cmd.take[psla_pkg::LAMP_LAYER] = 1'b1;
            end else if (free_for(lamp_st[psla_pkg::LAMP_LINK], psla_pkg::PRIO_LAYER)) begin
               cmd.take[psla_pkg::LAMP_LINK] = 1'b1;
               cmd.shared = 1'b1;
            end else if (free_for(lamp_st[psla_pkg::LAMP_BATTERY], psla_pkg::PRIO_LAYER)) begin
               cmd.take[psla_pkg::LAMP_BATTERY] = 1'b1;
               cmd.shared = 1'b1;
            end else begin
               status = psla_pkg::ST_BUSY;
            end
         end
      endcase
   end

endmodule

### rtl/psla_lamp.sv
// One lamp slot: ownership, blink timing, expiry and share deadline.
module psla_lamp #(
   parameter int TIME_BITS = psla_pkg::TIME_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     take,
   input  psla_pkg::cmd_type        cmd,
   input  logic [TIME_BITS-1:0]     now,
   input  logic [31:0]              share_timeout_ms,
   output psla_pkg::lamp_state_type state
);

`include "priority_status_lamp_arbiter_unit_defines.svh"

   psla_pkg::owner_type  owner_ff, owner_in, eff_owner;
   psla_pkg::prio_type   prio_ff, prio_in, eff_prio;
   logic                 lit_ff, lit_in, eff_lit;
   logic                 blinking_ff, blinking_in, eff_blinking;
   logic [15:0]          period_ff, eff_period;
   logic [TIME_BITS-1:0] expiry_ff, eff_expiry, expiry_sum;
   logic [TIME_BITS-1:0] next_ff, next_in, eff_next, period_sum;
   logic [TIME_BITS-1:0] share_ff, eff_share, share_sum;
   logic                 active, toggle, expire;

   always_comb begin
      eff_owner = take ? cmd.owner : owner_ff;
      eff_prio = take ? cmd.prio : prio_ff;
      eff_lit = take | lit_ff;
      eff_blinking = take ? cmd.blinking : blinking_ff;
      eff_period = take ? cmd.period : period_ff;
      period_sum = now + TIME_BITS'(eff_period);
      expiry_sum = now + TIME_BITS'(cmd.timeout);
      share_sum = cmd.shared ? (now + TIME_BITS'(share_timeout_ms)) : '0;
      eff_expiry = take ? expiry_sum : expiry_ff;
      eff_share = take ? share_sum : share_ff;
      eff_next = take ? period_sum : next_ff;

      active = (eff_owner != psla_pkg::OWN_NONE);
      toggle = active && eff_blinking && (now >= eff_next);
      expire = active && (((eff_share != '0) && (now >= eff_share)) || (now >= eff_expiry));

      next_in = toggle ? period_sum : eff_next;
      if (expire) begin
         owner_in = psla_pkg::OWN_NONE;
         prio_in = psla_pkg::PRIO_IDLE;
         lit_in = 1'b0;
         blinking_in = 1'b0;
      end else begin
         owner_in = eff_owner;
         prio_in = eff_prio;
         lit_in = eff_lit ^ toggle;
         blinking_in = eff_blinking;
      end
   end

   assign state.owner = owner_ff;
   assign state.prio = prio_ff;
   assign state.lit_next = lit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_ff <= psla_pkg::OWN_NONE;
         prio_ff <= psla_pkg::PRIO_IDLE;
         lit_ff <= 1'b0;
         blinking_ff <= 1'b0;
      end else if (step) begin
         owner_ff <= owner_in;
         prio_ff <= prio_in;
         lit_ff <= lit_in;
         blinking_ff <= blinking_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         period_ff <= eff_period;
         expiry_ff <= eff_expiry;
         next_ff <= next_in;
         share_ff <= eff_share;
      end
   end

   `PSLA_ASSERT_IMP(a_free_lamp_dark, owner_ff == psla_pkg::OWN_NONE, !lit_ff,
                    "free lamp is lit")
   `PSLA_ASSERT_IMP(a_free_lamp_idle, owner_ff == psla_pkg::OWN_NONE,
                    prio_ff == psla_pkg::PRIO_IDLE, "free lamp has a priority")
   `PSLA_ASSERT_NXT(a_take_owns, step && take && !expire, owner_ff != psla_pkg::OWN_NONE,
                    "assigned lamp has no owner")

endmodule

### rtl/priority_status_lamp_arbiter_unit.sv
// Top level of the status lamp arbiter: input and result registers, lamps, CSRs.
//
//  Channel  Direction  Signals
//  req      in         req_valid, req_ready, req_opcode, req_now_ms,
//                      req_charge_pct, req_link_state
//  rsp      out        rsp_valid, rsp_ready, rsp_lamps_lit, rsp_request_status
//  csr      in         csr_valid, csr_ready, csr_index, csr_data
//
// A transaction waits in the input register until the result register can take it;
// its result is then registered in the result register. Lamp state is updated as the
// transaction leaves the input register, so a new transaction is accepted every cycle
// unless the result is stalled. While the result is stalled, one further transaction
// waits in the input register. Reset clears the lamps and loads the register defaults.
// CSR writes are accepted in every cycle.
module priority_status_lamp_arbiter_unit #(
   parameter int LAYER_LAMP_PRESENT = psla_pkg::LAYER_LAMP_PRESENT_DEFAULT,
   parameter int TIME_BITS = psla_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_opcode,
   input  logic [31:0]                         req_now_ms,
   input  logic [6:0]                          req_charge_pct,
   input  logic [1:0]                          req_link_state,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_lamps_lit,
   output logic [1:0]                          rsp_request_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [psla_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]                         csr_data
);

`include "priority_status_lamp_arbiter_unit_defines.svh"

   logic                    s1_valid_ff, s1_valid_in;
   psla_pkg::op_type        s1_op_ff;
   logic [TIME_BITS-1:0]    s1_now_ff;
   logic [6:0]              s1_level_ff;
   logic [1:0]              s1_link_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              rsp_lit_ff;
   psla_pkg::outcome_type   rsp_status_ff;
   logic                    accept, advance;
   psla_pkg::cfg_type       cfg;
   psla_pkg::cmd_type       cmd;
   psla_pkg::outcome_type   status;
   psla_pkg::lamp_state_type lamp_st [psla_pkg::NUM_LAMPS];
   logic [2:0]              lit_next;

   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept = req_valid && req_ready;
   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_lamps_lit = rsp_lit_ff;
   assign rsp_request_status = rsp_status_ff;

   psla_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   psla_decode #(
      .LAYER_LAMP_PRESENT (LAYER_LAMP_PRESENT)
   ) u_decode (
      .op            (s1_op_ff),
      .charge_pct    (s1_level_ff),
      .link_state    (s1_link_ff),
      .cfg           (cfg),
      .lamp_st       (lamp_st),
      .cmd           (cmd),
      .status        (status)
   );

   for (genvar i = 0; i < psla_pkg::NUM_LAMPS; i++) begin : g_lamp
      psla_lamp #(
         .TIME_BITS (TIME_BITS)
      ) u_lamp (
         .clock            (clock),
         .reset            (reset),
         .step             (advance),
         .take             (cmd.take[i]),
         .cmd              (cmd),
         .now              (s1_now_ff),
         .share_timeout_ms (cfg.share_timeout_ms),
         .state            (lamp_st[i])
      );
      assign lit_next[i] = lamp_st[i].lit_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff <= psla_pkg::op_type'(req_opcode);
         s1_now_ff <= TIME_BITS'(req_now_ms);
         s1_level_ff <= req_charge_pct;
         s1_link_ff <= req_link_state;
      end
      if (advance) begin
         rsp_lit_ff <= lit_next;
         rsp_status_ff <= status;
      end
   end

   `PSLA_ASSERT_NXT(a_advance_fills_rsp, advance, rsp_valid_ff, "result register not loaded")
   `PSLA_ASSERT_IMP(a_empty_input_ready, !s1_valid_ff, req_ready, "empty input register not ready")
   `PSLA_ASSERT_NXT(a_poll_status, advance,
                    (rsp_status_ff == psla_pkg::ST_POLL) ==
                    ($past(s1_op_ff) == psla_pkg::OP_POLL), "poll status mismatch")
   `PSLA_ASSERT_IMP(a_absent_layer_dark, rsp_valid_ff,
                    (LAYER_LAMP_PRESENT != 0) || !rsp_lit_ff[2], "absent layer lamp is lit")

endmodule
